// File: design/csp28_pkg.sv
// Shared types, constants and character helpers for the 28-bit callsign packer.
`timescale 1ns / 1ps

package csp28_pkg;

    localparam int unsigned NUM_CHARS = 6;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_LONG = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // What kind of code an item resolves to.
    typedef enum logic [1:0] {
        K_CALC = 2'd0,
        K_CQ   = 2'd1,
        K_QRZ  = 2'd2,
        K_DE   = 2'd3
    } t_kind;

    // Fixed codes for the three tokens.
    localparam logic [27:0] CODE_CQ  = 28'd262177561;
    localparam logic [27:0] CODE_QRZ = 28'd262177562;
    localparam logic [27:0] CODE_DE  = 28'd267796945;

    // Place weights of the mixed radix 37*36*10*27*27*27.
    localparam logic [27:0] WT_0 = 28'd7085880;
    localparam logic [27:0] WT_1 = 28'd196830;
    localparam logic [27:0] WT_2 = 28'd19683;
    localparam logic [27:0] WT_3 = 28'd729;
    localparam logic [27:0] WT_4 = 28'd27;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UC    = 8'h43;
    localparam logic [7:0] CH_UD    = 8'h44;
    localparam logic [7:0] CH_UE    = 8'h45;
    localparam logic [7:0] CH_UQ    = 8'h51;
    localparam logic [7:0] CH_UR    = 8'h52;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    function automatic logic f_is_dig(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic f_is_let(input logic [7:0] c);
        return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ));
    endfunction

    function automatic logic f_is_spc(input logic [7:0] c);
        return c == CH_SPACE;
    endfunction

    function automatic logic [7:0] f_upcase(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) ? (c - CASE_OFS) : c;
    endfunction

    // Value of a head position: digit 0..9, letter 10..35, anything else 36.
    function automatic logic [5:0] f_head_val(input logic [7:0] c);
        logic [7:0] u;
        u = f_upcase(c);
        if (f_is_dig(c)) begin
            return 6'(c - CH_0);
        end else if (f_is_let(c)) begin
            return 6'(u - CH_UA) + 6'd10;
        end else begin
            return 6'd36;
        end
    endfunction

    // Value of a suffix position: letter 0..25, anything else 26.
    function automatic logic [4:0] f_tail_val(input logic [7:0] c);
        logic [7:0] u;
        u = f_upcase(c);
        if (f_is_let(c)) begin
            return 5'(u - CH_UA);
        end else begin
            return 5'd26;
        end
    endfunction

endpackage

// File: design/callsign_packer_28bit.sv
// Top level of the 28-bit callsign packer: input register, layout stage, packing stage.
`timescale 1ns / 1ps

// The block packs the six characters at a callsign position, together with the
// callsign length, into a 28-bit code and a status.
//
// Input channel: an item is taken at each rising edge where start is high and busy
// is low. Busy is held low, because the block accepts a new item in every cycle.
// Result channel: o_valid is high for exactly one cycle with o_call_code and o_status;
// the receiver has to take the item in that cycle, as it cannot stall the block.
//
// Throughput is one item per cycle. The item passes an input register, then a stage
// that decides tokens, prefix rewrites, the padded layout and the status and registers
// the per-position values, then a stage that forms the weighted sum with constant place
// weights and registers the result. Items leave in the order taken.
//
// Reset clears the valid bits of all stages, so nothing is delivered for items that
// were in flight. The data registers are not reset.
module callsign_packer_28bit
    import csp28_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_char_0,
    input  logic [7:0]  i_char_1,
    input  logic [7:0]  i_char_2,
    input  logic [7:0]  i_char_3,
    input  logic [7:0]  i_char_4,
    input  logic [7:0]  i_char_5,
    input  logic [3:0]  i_call_length,
    output logic        o_valid,
    output logic [27:0] o_call_code,
    output logic [1:0]  o_status
);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_char [NUM_CHARS];
    logic [3:0] r_len;

    // Layout stage registers.
    logic       r_lay_valid;
    t_status    r_lay_status;
    t_kind      r_lay_kind;
    logic [5:0] r_v0;
    logic [5:0] r_v1;
    logic [3:0] r_v2;
    logic [4:0] r_v3;
    logic [4:0] r_v4;
    logic [4:0] r_v5;

    // Layout stage next values.
    t_status    n_lay_status;
    t_kind      n_lay_kind;
    logic [5:0] n_v0;
    logic [5:0] n_v1;
    logic [3:0] n_v2;
    logic [4:0] n_v3;
    logic [4:0] n_v4;
    logic [4:0] n_v5;

    logic [7:0] u [NUM_CHARS];
    logic [7:0] w [NUM_CHARS];
    logic       tok_cq;
    logic       tok_qrz;
    logic       tok_de;
    logic       pfx_swz;
    logic       pfx_gui;
    logic       one_sym;
    logic       layout_ok;

    logic [27:0] n_sum;

    // The block never holds off the sender.
    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
        if (start && !busy) begin
            r_char[0] <= i_char_0;
            r_char[1] <= i_char_1;
            r_char[2] <= i_char_2;
            r_char[3] <= i_char_3;
            r_char[4] <= i_char_4;
            r_char[5] <= i_char_5;
            r_len     <= i_call_length;
        end
    end

    // Token tests, prefix rewrites and the padded six-position layout.
    always_comb begin
        for (int i = 0; i < NUM_CHARS; i++) begin
            u[i] = f_upcase(r_char[i]);
            w[i] = CH_SPACE;
        end

        tok_cq  = (u[0] == CH_UC) && (u[1] == CH_UQ) && (r_char[2] == CH_SPACE);
        tok_qrz = (u[0] == CH_UQ) && (u[1] == CH_UR) && (u[2] == CH_UZ)
                  && (r_char[3] == CH_SPACE);
        tok_de  = (u[0] == CH_UD) && (u[1] == CH_UE) && (r_char[2] == CH_SPACE);
        pfx_swz = (r_char[0] == CH_3) && (u[1] == CH_UD) && (u[2] == CH_UA)
                  && (r_char[3] == CH_0);
        pfx_gui = (r_char[0] == CH_3) && (u[1] == CH_UX) && f_is_let(r_char[2]);
        one_sym = !f_is_dig(r_char[2]) && f_is_dig(r_char[1]);

        if (pfx_swz) begin
            // The four-character prefix shrinks to three; the rest moves down by one.
            w[0] = CH_3;
            w[1] = CH_UD;
            w[2] = CH_0;
            for (int i = 4; i < NUM_CHARS; i++) begin
                if (4'(i) < r_len) begin
                    w[i - 1] = r_char[i];
                end
            end
        end else if (pfx_gui) begin
            // The two-character prefix becomes a single Q.
            w[0] = CH_UQ;
            for (int i = 2; i < NUM_CHARS; i++) begin
                if (4'(i) < r_len) begin
                    w[i - 1] = r_char[i];
                end
            end
        end else if (one_sym) begin
            // A one-symbol prefix gets a leading space so the digit lands in place two.
            for (int i = 0; i < NUM_CHARS - 1; i++) begin
                if (4'(i) < r_len) begin
                    w[i + 1] = r_char[i];
                end
            end
        end else begin
            for (int i = 0; i < NUM_CHARS; i++) begin
                if (4'(i) < r_len) begin
                    w[i] = r_char[i];
                end
            end
        end

        layout_ok = (f_is_dig(w[0]) || f_is_let(w[0]) || f_is_spc(w[0]))
                    && (f_is_dig(w[1]) || f_is_let(w[1]))
                    && f_is_dig(w[2])
                    && (f_is_let(w[3]) || f_is_spc(w[3]))
                    && (f_is_let(w[4]) || f_is_spc(w[4]))
                    && (f_is_let(w[5]) || f_is_spc(w[5]));

        n_lay_kind   = K_CALC;
        n_lay_status = ST_OK;
        priority if (r_len > 4'd6) begin
            n_lay_status = ST_LONG;
        end else if (tok_cq) begin
            n_lay_kind = K_CQ;
        end else if (tok_qrz) begin
            n_lay_kind = K_QRZ;
        end else if (tok_de) begin
            n_lay_kind = K_DE;
        end else if (!pfx_swz && !pfx_gui && one_sym && (r_len > 4'd5)) begin
            n_lay_status = ST_LONG;
        end else if (!layout_ok) begin
            n_lay_status = ST_BAD;
        end else begin
            n_lay_status = ST_OK;
        end

        n_v0 = f_head_val(w[0]);
        n_v1 = f_head_val(w[1]);
        n_v2 = 4'(f_head_val(w[2]));
        n_v3 = f_tail_val(w[3]);
        n_v4 = f_tail_val(w[4]);
        n_v5 = f_tail_val(w[5]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lay_valid <= 1'b0;
        end else begin
            r_lay_valid <= r_in_valid;
        end
        r_lay_status <= n_lay_status;
        r_lay_kind   <= n_lay_kind;
        r_v0         <= n_v0;
        r_v1         <= n_v1;
        r_v2         <= n_v2;
        r_v3         <= n_v3;
        r_v4         <= n_v4;
        r_v5         <= n_v5;
    end

    // Mixed-radix sum as constant-weight products; the largest value is 262177559.
    assign n_sum = 28'(r_v0) * WT_0
                 + 28'(r_v1) * WT_1
                 + 28'(r_v2) * WT_2
                 + 28'(r_v3) * WT_3
                 + 28'(r_v4) * WT_4
                 + 28'(r_v5);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_lay_valid;
        end
        o_status <= r_lay_status;
        if (r_lay_status != ST_OK) begin
            o_call_code <= '0;
        end else begin
            unique case (r_lay_kind)
                K_CQ:    o_call_code <= CODE_CQ;
                K_QRZ:   o_call_code <= CODE_QRZ;
                K_DE:    o_call_code <= CODE_DE;
                default: o_call_code <= n_sum;
            endcase
        end
    end

endmodule

// File: dv/callsign_code_checker.sv
// Checker that predicts and compares the packed callsign code and status of every item.
`timescale 1ns / 1ps

module callsign_code_checker
    import csp28_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [7:0]  i_char_0,
    input  logic [7:0]  i_char_1,
    input  logic [7:0]  i_char_2,
    input  logic [7:0]  i_char_3,
    input  logic [7:0]  i_char_4,
    input  logic [7:0]  i_char_5,
    input  logic [3:0]  i_call_length,
    input  logic        i_valid,
    input  logic [27:0] i_call_code,
    input  logic [1:0]  i_status,
    output int          o_errors,
    output int          o_pending
);

    // Size of the full mixed-radix range; the CQ and QRZ tokens sit just above it.
    localparam int unsigned RADIX_SPAN    = 37 * 36 * 10 * 27 * 27 * 27;
    localparam int unsigned TOKEN_CQ_CODE  = RADIX_SPAN + 1;
    localparam int unsigned TOKEN_QRZ_CODE = RADIX_SPAN + 2;
    localparam int unsigned TOKEN_DE_CODE  = 267796945;

    typedef struct packed {
        logic [27:0] code;
        t_status     status;
    } t_call_result;

    t_call_result expected_calls[$];

    function automatic logic numeral_char(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic alpha_char(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
    endfunction

    // Digit 0..9, letter 10..35, anything else 36.
    function automatic int unsigned symbol_value(input logic [7:0] c);
        if (numeral_char(c)) begin
            return 32'(c - 8'h30);
        end
        if (alpha_char(c)) begin
            return 32'(upper(c) - 8'h41) + 10;
        end
        return 36;
    endfunction

    function automatic t_call_result pack_call(input logic [5:0][7:0] c, input logic [3:0] len);
        logic [7:0]   w [6];
        logic         layout_ok;
        int unsigned  acc;
        t_call_result r;
        r.code   = '0;
        r.status = ST_LONG;
        if (len > 4'd6) begin
            return r;
        end
        r.status = ST_OK;
        if (upper(c[0]) == "C" && upper(c[1]) == "Q" && c[2] == " ") begin
            r.code = 28'(TOKEN_CQ_CODE);
            return r;
        end
        if (upper(c[0]) == "Q" && upper(c[1]) == "R" && upper(c[2]) == "Z" && c[3] == " ") begin
            r.code = 28'(TOKEN_QRZ_CODE);
            return r;
        end
        if (upper(c[0]) == "D" && upper(c[1]) == "E" && c[2] == " ") begin
            r.code = 28'(TOKEN_DE_CODE);
            return r;
        end

        for (int i = 0; i < 6; i++) w[i] = " ";
        if (c[0] == "3" && upper(c[1]) == "D" && upper(c[2]) == "A" && c[3] == "0") begin
            w[0] = "3";
            w[1] = "D";
            w[2] = "0";
            for (int i = 4; i < len; i++) w[i - 1] = c[i];
        end else if (c[0] == "3" && upper(c[1]) == "X" && alpha_char(c[2])) begin
            w[0] = "Q";
            for (int i = 2; i < len; i++) w[i - 1] = c[i];
        end else if (!numeral_char(c[2]) && numeral_char(c[1])) begin
            // One-symbol prefix: shifted right by one, so six characters do not fit.
            if (len > 4'd5) begin
                r.status = ST_LONG;
                return r;
            end
            for (int i = 0; i < len; i++) w[i + 1] = c[i];
        end else begin
            for (int i = 0; i < len; i++) w[i] = c[i];
        end

        layout_ok = (numeral_char(w[0]) || alpha_char(w[0]) || w[0] == " ")
                 && (numeral_char(w[1]) || alpha_char(w[1])) && numeral_char(w[2]);
        for (int i = 3; i < 6; i++) layout_ok = layout_ok && (alpha_char(w[i]) || w[i] == " ");
        if (!layout_ok) begin
            r.status = ST_BAD;
            return r;
        end

        acc = symbol_value(w[0]);
        acc = 36 * acc + symbol_value(w[1]);
        acc = 10 * acc + symbol_value(w[2]);
        for (int i = 3; i < 6; i++) acc = 27 * acc + (symbol_value(w[i]) - 10);
        r.code = acc[27:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_call_result want;
        if (i_rst_n) begin
            if (i_start && !i_busy) begin
                expected_calls.push_back(pack_call({i_char_5, i_char_4, i_char_3, i_char_2,
                                                    i_char_1, i_char_0}, i_call_length));
            end
            if (i_valid) begin
                if (expected_calls.size() == 0) begin
                    $error("result with no item outstanding: call_code %0d status %0d",
                           i_call_code, i_status);
                    o_errors = o_errors + 1;
                end else begin
                    want = expected_calls.pop_front();
                    if (i_call_code !== want.code) begin
                        $error("call_code: expected %0d, actual %0d", want.code, i_call_code);
                        o_errors = o_errors + 1;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, i_status);
                        o_errors = o_errors + 1;
                    end
                end
            end
        end
        o_pending = expected_calls.size();
    end

endmodule

// File: dv/testbench.sv
// Top of the callsign packer bench: clock, reset, item stimulus and the final verdict.
`timescale 1ns / 1ps

// The bench drives callsign items into the packer and leaves all prediction and
// comparison to the checker beside it. Inputs change on the falling clock edge so
// that both the block and the checker see stable values at the rising edge.
module testbench;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_char_0;
    logic [7:0]  i_char_1;
    logic [7:0]  i_char_2;
    logic [7:0]  i_char_3;
    logic [7:0]  i_char_4;
    logic [7:0]  i_char_5;
    logic [3:0]  i_call_length;
    logic        o_valid;
    logic [27:0] o_call_code;
    logic [1:0]  o_status;
    int          call_errors;
    int          calls_pending;

    // Items still to go in the current burst before the sender pauses.
    int          burst_left;

    callsign_packer_28bit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_char_0      (i_char_0),
        .i_char_1      (i_char_1),
        .i_char_2      (i_char_2),
        .i_char_3      (i_char_3),
        .i_char_4      (i_char_4),
        .i_char_5      (i_char_5),
        .i_call_length (i_call_length),
        .o_valid       (o_valid),
        .o_call_code   (o_call_code),
        .o_status      (o_status)
    );

    callsign_code_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_char_0      (i_char_0),
        .i_char_1      (i_char_1),
        .i_char_2      (i_char_2),
        .i_char_3      (i_char_3),
        .i_char_4      (i_char_4),
        .i_char_5      (i_char_5),
        .i_call_length (i_call_length),
        .i_valid       (o_valid),
        .i_call_code   (o_call_code),
        .i_status      (o_status),
        .o_errors      (call_errors),
        .o_pending     (calls_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block stops delivering results or never drops busy.
    initial begin
        #2_000_000;
        $display("callsign_packer_28bit test failed");
        $finish;
    end

    // Letters keep their case at random, since the block must ignore case.
    function automatic logic [7:0] any_case(input logic [7:0] c);
        return $urandom_range(0, 1) ? (c | 8'h20) : c;
    endfunction

    function automatic logic [7:0] rand_letter();
        return any_case(8'("A" + $urandom_range(0, 25)));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // A suffix position: mostly a letter, sometimes a padding space.
    function automatic logic [7:0] tail_char();
        return ($urandom_range(0, 4) == 0) ? 8'h20 : rand_letter();
    endfunction

    function automatic logic [7:0] head_char();
        return $urandom_range(0, 1) ? rand_letter() : rand_digit();
    endfunction

    // Turns a short text into the six character positions, padded with spaces.
    function automatic logic [5:0][7:0] text_chars(input string s);
        logic [5:0][7:0] ch;
        for (int i = 0; i < 6; i++) ch[i] = (i < s.len()) ? s[i] : 8'h20;
        return ch;
    endfunction

    // Presents one item, holds it until the block takes it, and returns at the
    // following falling edge with start still high.
    task automatic send_call(input logic [5:0][7:0] ch, input logic [3:0] len);
        start         <= 1'b1;
        i_char_0      <= ch[0];
        i_char_1      <= ch[1];
        i_char_2      <= ch[2];
        i_char_3      <= ch[3];
        i_char_4      <= ch[4];
        i_char_5      <= ch[5];
        i_call_length <= len;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    // Sends one item inside the burst pattern: when a burst runs out, the sender
    // drops start for a random gap and then draws the length of the next burst.
    // Long bursts give stretches with no idling at all.
    task automatic issue_call(input logic [5:0][7:0] ch, input logic [3:0] len);
        send_call(ch, len);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(0, 10);
        end else begin
            burst_left = burst_left - 1;
        end
    endtask

    // Mostly well-formed callsigns of every layout with random content, plus
    // corrupted ones and pure noise. Positions past the length are sometimes
    // filled with junk, because the token and prefix tests still look at them.
    task automatic send_random_call();
        logic [5:0][7:0] ch;
        logic [3:0]      len;
        int unsigned     kind;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 6; i++) ch[i] = tail_char();
        len = 4'($urandom_range(3, 6));
        if (kind < 8) begin
            case ($urandom_range(0, 2))
                0: begin
                    ch[0] = any_case("C");
                    ch[1] = any_case("Q");
                    ch[2] = 8'h20;
                end
                1: begin
                    ch[0] = any_case("Q");
                    ch[1] = any_case("R");
                    ch[2] = any_case("Z");
                    ch[3] = 8'h20;
                end
                default: begin
                    ch[0] = any_case("D");
                    ch[1] = any_case("E");
                    ch[2] = 8'h20;
                end
            endcase
            len = 4'($urandom_range(0, 15));
        end else if (kind < 16) begin
            ch[0] = "3";
            ch[1] = any_case("D");
            ch[2] = any_case("A");
            ch[3] = "0";
            len   = 4'($urandom_range(0, 6));
        end else if (kind < 24) begin
            ch[0] = "3";
            ch[1] = any_case("X");
            ch[2] = rand_letter();
            ch[3] = rand_digit();
        end else if (kind < 50) begin
            ch[0] = head_char();
            ch[1] = rand_digit();
            ch[2] = rand_letter();
            len   = 4'($urandom_range(2, 6));
        end else if (kind < 90) begin
            ch[0] = ($urandom_range(0, 5) == 0) ? 8'h20 : head_char();
            ch[1] = head_char();
            ch[2] = rand_digit();
            if (kind >= 80) begin
                ch[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
            end
        end else begin
            for (int i = 0; i < 6; i++) ch[i] = 8'($urandom_range(0, 255));
            len = 4'($urandom_range(0, 15));
        end
        for (int i = 0; i < 6; i++) begin
            if (i >= len && $urandom_range(0, 2) == 0) begin
                ch[i] = 8'($urandom_range(0, 255));
            end
        end
        issue_call(ch, len);
    endtask

    initial begin
        // Every input is known from time zero, while reset is held low.
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_char_0      = '0;
        i_char_1      = '0;
        i_char_2      = '0;
        i_char_3      = '0;
        i_char_4      = '0;
        i_char_5      = '0;
        i_call_length = '0;
        burst_left    = $urandom_range(0, 6);
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Tokens, in both cases and with trailing characters; a length over six
        // wins over a token.
        issue_call(text_chars("CQ"), 4'd2);
        issue_call(text_chars("cq xyz"), 4'd0);
        issue_call(text_chars("QRZ"), 4'd3);
        issue_call(text_chars("qRz ab"), 4'd15);
        issue_call(text_chars("DE"), 4'd2);
        issue_call(text_chars("dE K1A"), 4'd6);
        // Swaziland and Guinea prefix rewrites.
        issue_call(text_chars("3DA0AB"), 4'd6);
        issue_call(text_chars("3da0x"), 4'd5);
        issue_call(text_chars("3DA0"), 4'd4);
        issue_call(text_chars("3XA1BC"), 4'd6);
        issue_call(text_chars("3xz7"), 4'd4);
        // One-symbol prefix: fits at five characters, too long at six.
        issue_call(text_chars("K1ABC"), 4'd5);
        issue_call(text_chars("K1ABCD"), 4'd6);
        issue_call(text_chars("W1AW"), 4'd4);
        // Plain two-symbol prefixes at the ends of the code range.
        issue_call(text_chars("AB1CDE"), 4'd6);
        issue_call(text_chars("ab1cde"), 4'd6);
        issue_call(text_chars("ZZ9ZZZ"), 4'd6);
        issue_call(text_chars("009AAA"), 4'd6);
        issue_call(text_chars(" A0"), 4'd3);
        // Bad layouts and lengths over six, with the extreme byte values.
        issue_call(text_chars(""), 4'd0);
        issue_call(text_chars("AB1CDE"), 4'd7);
        issue_call(text_chars("AB1C1E"), 4'd6);
        issue_call(text_chars("A!1ABC"), 4'd6);
        issue_call({6{8'hFF}}, 4'd6);
        issue_call({6{8'h00}}, 4'd6);
        issue_call({6{8'h00}}, 4'd15);

        repeat (850) send_random_call();
        start <= 1'b0;

        // The block holds nothing beyond its pipeline, so once the last result is in
        // only the pipeline depth is left to watch for stray results.
        while (calls_pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (call_errors == 0) begin
            $display("callsign_packer_28bit test passed");
        end else begin
            $display("callsign_packer_28bit test failed");
        end
        $finish;
    end

endmodule
